>>> rtl/fep_pkg.sv
`default_nettype none

package fep_pkg;

   localparam int INTENSITY_W = 6;
   localparam int COLOR_W     = 24;

   localparam logic [INTENSITY_W-1:0] PALETTE_LAST = 6'd36;

   localparam logic [COLOR_W-1:0] PALETTE [0:36] = '{
      24'h070707, 24'h1F0707, 24'h2F0F07, 24'h470F07, 24'h571707, 24'h671F07,
      24'h771F07, 24'h8F2707, 24'h9F2F07, 24'hAF3F07, 24'hBF4707, 24'hC74707,
      24'hDF4F07, 24'hDF5707, 24'hDF5707, 24'hD75F07, 24'hD75F07, 24'hD7670F,
      24'hCF6F0F, 24'hCF770F, 24'hCF7F0F, 24'hCF8717, 24'hC78717, 24'hC78F17,
      24'hC7971F, 24'hBF9F1F, 24'hBF9F1F, 24'hBFA727, 24'hBFA727, 24'hBFAF2F,
      24'hB7AF2F, 24'hB7B72F, 24'hB7B737, 24'hCFCF6F, 24'hDFDF9F, 24'hEFEFC7,
      24'hFFFFFF
   };

   localparam logic [1:0] RND_ALIAS_ZERO = 2'd3;

   typedef enum logic {
      FEP_OP_PROPAGATE = 1'b0,
      FEP_OP_READ      = 1'b1
   } fep_op_type;

   typedef enum logic [1:0] {
      FEP_ST_CLEAR = 2'd0,
      FEP_ST_IDLE  = 2'd1,
      FEP_ST_READ  = 2'd2,
      FEP_ST_EXEC  = 2'd3
   } fep_state_type;

   typedef struct packed {
      logic       command;
      logic [1:0] rnd;
      logic [8:0] read_x;
      logic [7:0] read_y;
   } fep_req_type;

   typedef struct packed {
      logic [INTENSITY_W-1:0] intensity;
      logic [COLOR_W-1:0]     color;
      logic                   wrote;
      logic                   frame_done;
   } fep_rsp_type;

   // decoded command as it travels through the queue
   typedef struct packed {
      fep_op_type op;
      logic       in_range;
      logic       wr_en;
      logic       decay;
      logic       frame_done;
   } fep_ctl_type;

   function automatic logic [COLOR_W-1:0] palette_color(input logic [INTENSITY_W-1:0] level);
      logic [INTENSITY_W-1:0] idx;
      idx = (level > PALETTE_LAST) ? PALETTE_LAST : level;
      return PALETTE[idx];
   endfunction

endpackage

`default_nettype wire

>>> rtl/fep_ram.sv
`default_nettype none

module fep_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 64000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/fep_queue.sv
`default_nettype none

module fep_queue #(
   parameter int WIDTH = 37,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] head_data,
   output logic                  full,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/fep_front.sv
`default_nettype none

module fep_front #(
   parameter int FRAME_WIDTH  = 320,
   parameter int FRAME_HEIGHT = 200,
   parameter int ADDR_W       = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire fep_pkg::fep_req_type req_data,
   input  wire logic                 clear_done,
   input  wire logic                 q_full,
   output logic                      push,
   output fep_pkg::fep_ctl_type      ctl,
   output logic [ADDR_W-1:0]         rd_addr,
   output logic [ADDR_W-1:0]         wr_addr
);

   import fep_pkg::*;

   localparam int COL_W = $clog2(FRAME_WIDTH);
   localparam int ROW_W = $clog2(FRAME_HEIGHT);

   logic [COL_W-1:0]  scan_col_ff, scan_col_in;
   logic [ROW_W-1:0]  scan_row_ff, scan_row_in;
   logic [ADDR_W-1:0] scan_addr_ff, scan_addr_in;

   logic [1:0]       r;
   logic [COL_W+1:0] tx_plus;
   logic [COL_W+1:0] r_ext;
   logic             edge_ok;
   logic             row_last;
   logic             col_last;
   logic             is_read;

   assign req_ready = clear_done && !q_full;
   assign push      = req_valid && req_ready;
   assign is_read   = (req_data.command == FEP_OP_READ);

   always_comb begin
      r        = (req_data.rnd == RND_ALIAS_ZERO) ? 2'd0 : req_data.rnd;
      r_ext    = (COL_W+2)'(r);
      tx_plus  = (COL_W+2)'(scan_col_ff) + (COL_W+2)'(1);
      edge_ok  = (tx_plus >= r_ext) && ((tx_plus - r_ext) < (COL_W+2)'(FRAME_WIDTH));
      row_last = ((ROW_W+1)'(scan_row_ff) + (ROW_W+1)'(1)) >= (ROW_W+1)'(FRAME_HEIGHT);
      col_last = ((COL_W+1)'(scan_col_ff) + (COL_W+1)'(1)) >= (COL_W+1)'(FRAME_WIDTH);

      ctl.op         = is_read ? FEP_OP_READ : FEP_OP_PROPAGATE;
      ctl.in_range   = (int'(req_data.read_x) < FRAME_WIDTH) &&
                       (int'(req_data.read_y) < FRAME_HEIGHT);
      ctl.wr_en      = !is_read && edge_ok;
      ctl.decay      = r[0];
      ctl.frame_done = !is_read && row_last && col_last;

      // read: row times width plus column; propagate: the scan pixel itself
      if (is_read) begin
         rd_addr = ADDR_W'(req_data.read_y) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(req_data.read_x);
      end else begin
         rd_addr = scan_addr_ff;
      end
      // one row up, shifted by 1 - r
      wr_addr = scan_addr_ff - ADDR_W'(FRAME_WIDTH) + ADDR_W'(1) - ADDR_W'(r);

      scan_col_in  = scan_col_ff;
      scan_row_in  = scan_row_ff;
      scan_addr_in = scan_addr_ff;
      if (push && !is_read) begin
         if (row_last) begin
            scan_row_in = ROW_W'(1);
            if (col_last) begin
               scan_col_in  = '0;
               scan_addr_in = ADDR_W'(FRAME_WIDTH);
            end else begin
               scan_col_in  = scan_col_ff + COL_W'(1);
               scan_addr_in = ADDR_W'(FRAME_WIDTH) + ADDR_W'(scan_col_ff) + ADDR_W'(1);
            end
         end else begin
            scan_row_in  = scan_row_ff + ROW_W'(1);
            scan_addr_in = scan_addr_ff + ADDR_W'(FRAME_WIDTH);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_col_ff  <= '0;
         scan_row_ff  <= ROW_W'(1);
         scan_addr_ff <= ADDR_W'(FRAME_WIDTH);
      end else begin
         scan_col_ff  <= scan_col_in;
         scan_row_ff  <= scan_row_in;
         scan_addr_ff <= scan_addr_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/fep_back.sv
`default_nettype none

module fep_back #(
   parameter int FRAME_WIDTH  = 320,
   parameter int FRAME_HEIGHT = 200,
   parameter int LEVELS       = 37,
   parameter int ADDR_W       = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   output logic                                     clear_done,
   input  wire logic                                q_empty,
   output logic                                     pop,
   input  wire fep_pkg::fep_ctl_type                head_ctl,
   input  wire logic [ADDR_W-1:0]                   head_rd_addr,
   input  wire logic [ADDR_W-1:0]                   head_wr_addr,
   output logic                                     ram_wr_en,
   output logic [ADDR_W-1:0]                        ram_wr_addr,
   output logic [fep_pkg::INTENSITY_W-1:0]          ram_wr_data,
   output logic                                     ram_rd_en,
   output logic [ADDR_W-1:0]                        ram_rd_addr,
   input  wire logic [fep_pkg::INTENSITY_W-1:0]     ram_rd_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output fep_pkg::fep_rsp_type                     rsp_data
);

   import fep_pkg::*;

   localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(FRAME_WIDTH * FRAME_HEIGHT - 1);
   localparam logic [ADDR_W-1:0] BOTTOM_BASE = ADDR_W'((FRAME_HEIGHT - 1) * FRAME_WIDTH);
   localparam logic [INTENSITY_W-1:0] TOP_LEVEL = INTENSITY_W'(LEVELS - 1);

   fep_state_type state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   fep_ctl_type       cur_ctl_ff, cur_ctl_in;
   logic [ADDR_W-1:0] cur_rd_addr_ff, cur_rd_addr_in;
   logic [ADDR_W-1:0] cur_wr_addr_ff, cur_wr_addr_in;

   logic        rsp_valid_ff, rsp_valid_in;
   fep_rsp_type rsp_data_ff, rsp_data_in;

   logic                   out_free;
   logic [INTENSITY_W-1:0] level;
   fep_rsp_type            result;

   assign clear_done  = (state_ff != FEP_ST_CLEAR);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;
   assign ram_rd_en   = (state_ff == FEP_ST_READ);
   assign ram_rd_addr = cur_rd_addr_ff;

   // decayed value, floored at zero
   always_comb begin
      level = (ram_rd_data > INTENSITY_W'(cur_ctl_ff.decay))
            ? ram_rd_data - INTENSITY_W'(cur_ctl_ff.decay) : '0;
      result = '0;
      if (cur_ctl_ff.op == FEP_OP_READ) begin
         if (cur_ctl_ff.in_range) begin
            result.intensity = ram_rd_data;
            result.color     = palette_color(ram_rd_data);
         end
      end else begin
         result.intensity  = cur_ctl_ff.wr_en ? level : '0;
         result.wrote      = cur_ctl_ff.wr_en;
         result.frame_done = cur_ctl_ff.frame_done;
      end
   end

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      cur_ctl_in     = cur_ctl_ff;
      cur_rd_addr_in = cur_rd_addr_ff;
      cur_wr_addr_in = cur_wr_addr_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      pop            = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = cur_wr_addr_ff;
      ram_wr_data    = level;

      case (state_ff)
         FEP_ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = (clr_addr_ff >= BOTTOM_BASE) ? TOP_LEVEL : '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = FEP_ST_IDLE;
            end
         end
         FEP_ST_IDLE: begin
            if (!q_empty) begin
               pop            = 1'b1;
               cur_ctl_in     = head_ctl;
               cur_rd_addr_in = head_rd_addr;
               cur_wr_addr_in = head_wr_addr;
               state_in       = FEP_ST_READ;
            end
         end
         FEP_ST_READ: begin
            state_in = FEP_ST_EXEC;
         end
         FEP_ST_EXEC: begin
            // write back and retire together, once the result slot is free
            if (out_free) begin
               ram_wr_en    = (cur_ctl_ff.op == FEP_OP_PROPAGATE) && cur_ctl_ff.wr_en;
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
               state_in     = FEP_ST_IDLE;
            end
         end
         default: begin
            state_in = FEP_ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FEP_ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ctl_ff     <= cur_ctl_in;
      cur_rd_addr_ff <= cur_rd_addr_in;
      cur_wr_addr_ff <= cur_wr_addr_in;
      rsp_data_ff    <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      !(pop && (state_ff == FEP_ST_CLEAR)))
      else $error("queue popped during clear pass");

   a_exec_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FEP_ST_EXEC) |-> ($past(state_ff) == FEP_ST_READ ||
                                     $past(state_ff) == FEP_ST_EXEC))
      else $error("execute entered without a store read");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !rsp_valid_ff) |-> (state_ff == FEP_ST_EXEC))
      else $error("result raised outside execute");

   a_clear_wraps_once: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == FEP_ST_CLEAR) && (clr_addr_ff == LAST_ADDR)) |=>
         (state_ff == FEP_ST_IDLE))
      else $error("clear pass did not finish at last entry");
`endif

endmodule

`default_nettype wire

>>> rtl/fire_effect_propagation.sv
`default_nettype none

// Doom-style fire store: a FRAME_WIDTH x FRAME_HEIGHT array of 6-bit
// intensities held in one RAM with a registered read port. Command 0
// (propagate) takes the next pixel of the internal scan (column outer,
// row 1..FRAME_HEIGHT-1 inner), decays it by rnd[0] and writes it one row up,
// shifted by 1 - rnd (rnd 3 acts as 0); a write that would fall off a side
// is dropped (wrote = 0). Command 1 (read) returns the intensity and RGB
// 8:8:8 palette color at read_x, read_y; out-of-frame reads return zeros.
// Every transaction gives exactly one result. The front decodes requests and
// walks the scan, a two-entry queue decouples it from the back, which does
// the RAM read-modify-write. The back takes one transaction at a time
// from the queue through its read and execute-and-write states on the
// single store and pops the next only after the current one has retired;
// execute waits while the result slot is full. After reset the back sweeps
// all FRAME_WIDTH * FRAME_HEIGHT entries (64000 at defaults) to the initial
// image, one entry per cycle; req_ready stays low until that sweep is done.

module fire_effect_propagation #(
   parameter int FRAME_WIDTH  = 320,
   parameter int FRAME_HEIGHT = 200,
   parameter int LEVELS       = 37
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire fep_pkg::fep_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output fep_pkg::fep_rsp_type      rsp_data
);

   import fep_pkg::*;

   localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CTL_W  = $bits(fep_ctl_type);
   localparam int QW     = CTL_W + 2 * ADDR_W;

   // front -> queue
   logic              clear_done;
   logic              q_full;
   logic              q_empty;
   logic              push;
   logic              pop;
   fep_ctl_type       front_ctl;
   logic [ADDR_W-1:0] front_rd_addr;
   logic [ADDR_W-1:0] front_wr_addr;
   logic [QW-1:0]     q_in;
   logic [QW-1:0]     q_head;

   // queue -> back
   fep_ctl_type       head_ctl;
   logic [ADDR_W-1:0] head_rd_addr;
   logic [ADDR_W-1:0] head_wr_addr;

   // back <-> store
   logic                   ram_wr_en;
   logic [ADDR_W-1:0]      ram_wr_addr;
   logic [INTENSITY_W-1:0] ram_wr_data;
   logic                   ram_rd_en;
   logic [ADDR_W-1:0]      ram_rd_addr;
   logic [INTENSITY_W-1:0] ram_rd_data;

   fep_front #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT),
      .ADDR_W       (ADDR_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .clear_done (clear_done),
      .q_full     (q_full),
      .push       (push),
      .ctl        (front_ctl),
      .rd_addr    (front_rd_addr),
      .wr_addr    (front_wr_addr)
   );

   // queue entry: decoded control, read address, write address
   assign q_in = {front_ctl, front_rd_addr, front_wr_addr};
   assign {head_ctl, head_rd_addr, head_wr_addr} = q_head;

   fep_queue #(
      .WIDTH (QW),
      .DEPTH (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (q_in),
      .pop       (pop),
      .head_data (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   fep_back #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT),
      .LEVELS       (LEVELS),
      .ADDR_W       (ADDR_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .clear_done   (clear_done),
      .q_empty      (q_empty),
      .pop          (pop),
      .head_ctl     (head_ctl),
      .head_rd_addr (head_rd_addr),
      .head_wr_addr (head_wr_addr),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

   // intensity store
   fep_ram #(
      .WIDTH (INTENSITY_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire
